/* design/isq_pkg.sv */
// Shared constants, command and status codes, and item types for the sequence store.
package isq_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int DOUT_W   = 32;
  localparam int LEN_W    = 7;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  // OR tree: taps are merged in groups, then the group results are merged
  localparam int GROUP   = 8;
  localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_WRITE = 2'd1;
  localparam logic [1:0] CELL_SHUP  = 2'd2;
  localparam logic [1:0] CELL_SHDN  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DOUT_W-1:0]   data_out;
    logic [LEN_W-1:0]    length;
  } out_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic [1:0]            op;
    logic [IDX_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  tap_en;
  } cell_ctrl_t;

endpackage

/* design/indexed_sequence_store.sv */
// Top level of the indexed sequence store: sequencer, cell chain and read tree.
// Each item passes from acceptance to result through the accepting state, an
// execute state in which every cell of the chain shifts or writes at once and the
// addressed word is tapped, a state for the first level of the read OR tree, and
// a state that loads the output register. in_ready is high only in the accepting
// state, so no new item is taken before the last has loaded its result; a result
// waits in the output register without blocking acceptance of the next item.
// Insert, erase, append, replace, read and clear all follow the same schedule.
module indexed_sequence_store (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  isq_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output isq_pkg::out_t out_item
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_TREE = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  isq_pkg::in_t                    item_r;
  logic [isq_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [isq_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic                            keep_r, keep_nxt;
  logic                            out_valid_r;
  isq_pkg::out_t                   out_r;
  isq_pkg::cell_ctrl_t             ctrl;
  logic [isq_pkg::CMP_W-1:0]       n_ext, p_ext, cap_ext;
  logic [isq_pkg::DATA_WIDTH-1:0]  cell_data [isq_pkg::CAPACITY];
  logic [isq_pkg::DATA_WIDTH-1:0]  cell_tap  [isq_pkg::CAPACITY];
  logic [isq_pkg::DATA_WIDTH-1:0]  read_word;
  logic                            load_out;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign n_ext   = isq_pkg::CMP_W'(count_r);
  assign p_ext   = isq_pkg::CMP_W'(item_r.position);
  assign cap_ext = isq_pkg::CMP_W'(isq_pkg::CAPACITY);

  // Command decode: only acts in the execute cycle
  always_comb begin
    ctrl.op     = isq_pkg::CELL_HOLD;
    ctrl.pos    = isq_pkg::IDX_W'(item_r.position);
    ctrl.wdata  = isq_pkg::DATA_WIDTH'(item_r.value);
    ctrl.tap_en = (state_r == S_EXEC);
    count_nxt   = count_r;
    status_nxt  = isq_pkg::ST_OK;
    keep_nxt    = 1'b0;
    if (state_r == S_EXEC) begin
      unique case (item_r.command)
        isq_pkg::CMD_APPEND: begin
          if (n_ext >= cap_ext) begin
            status_nxt = isq_pkg::ST_FULL;
          end else begin
            ctrl.op   = isq_pkg::CELL_WRITE;
            ctrl.pos  = isq_pkg::IDX_W'(count_r);
            count_nxt = count_r + 1'b1;
          end
        end
        isq_pkg::CMD_INSERT: begin
          if (p_ext > n_ext) begin
            status_nxt = isq_pkg::ST_RANGE;
          end else if (n_ext >= cap_ext) begin
            status_nxt = isq_pkg::ST_FULL;
          end else begin
            ctrl.op   = isq_pkg::CELL_SHUP;
            count_nxt = count_r + 1'b1;
          end
        end
        isq_pkg::CMD_ERASE: begin
          if (p_ext >= n_ext) begin
            status_nxt = isq_pkg::ST_RANGE;
          end else begin
            ctrl.op   = isq_pkg::CELL_SHDN;
            count_nxt = count_r - 1'b1;
            keep_nxt  = 1'b1;
          end
        end
        isq_pkg::CMD_REPLACE: begin
          if (p_ext >= n_ext) begin
            status_nxt = isq_pkg::ST_RANGE;
          end else begin
            ctrl.op = isq_pkg::CELL_WRITE;
          end
        end
        isq_pkg::CMD_READ: begin
          if (p_ext >= n_ext) status_nxt = isq_pkg::ST_RANGE;
          else keep_nxt = 1'b1;
        end
        isq_pkg::CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: status_nxt = isq_pkg::ST_RANGE;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_TREE;
      S_TREE:  state_nxt = S_DONE;
      S_DONE:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_item;
    if (state_r == S_EXEC) begin
      status_r <= status_nxt;
      keep_r   <= keep_nxt;
    end
    if (load_out) begin
      out_r.status   <= status_r;
      out_r.data_out <= keep_r ? isq_pkg::DOUT_W'(read_word) : '0;
      out_r.length   <= isq_pkg::LEN_W'(count_r);
    end
  end

  for (genvar g = 0; g < isq_pkg::CAPACITY; g++) begin : g_cell
    logic [isq_pkg::DATA_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[g-1];
    end
    if (g == isq_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[g+1];
    end
    isq_cell u_cell (
      .clk        (clk),
      .cell_idx   (isq_pkg::IDX_W'(g)),
      .ctrl       (ctrl),
      .left_data  (left_w),
      .right_data (right_w),
      .data_r     (cell_data[g]),
      .tap_r      (cell_tap[g])
    );
  end

  isq_or_tree u_tree (
    .clk  (clk),
    .taps (cell_tap),
    .word (read_word)
  );

endmodule

/* design/isq_cell.sv */
// One storage cell of the chain: holds one entry and shifts with its neighbors.
module isq_cell (
  input  logic                                clk,
  input  logic [isq_pkg::IDX_W-1:0]           cell_idx,
  input  isq_pkg::cell_ctrl_t                 ctrl,
  input  logic [isq_pkg::DATA_WIDTH-1:0]      left_data,
  input  logic [isq_pkg::DATA_WIDTH-1:0]      right_data,
  output logic [isq_pkg::DATA_WIDTH-1:0]      data_r,
  output logic [isq_pkg::DATA_WIDTH-1:0]      tap_r
);

  logic [isq_pkg::DATA_WIDTH-1:0] data_nxt;
  logic                           hit;

  assign hit = (cell_idx == ctrl.pos);

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      isq_pkg::CELL_WRITE: begin
        if (hit) data_nxt = ctrl.wdata;
      end
      isq_pkg::CELL_SHUP: begin
        // cells above the slot take their left neighbor, the slot takes the new word
        if (hit) data_nxt = ctrl.wdata;
        else if (cell_idx > ctrl.pos) data_nxt = left_data;
      end
      isq_pkg::CELL_SHDN: begin
        if (cell_idx >= ctrl.pos) data_nxt = right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    // capture the word before any update of this cycle
    if (ctrl.tap_en) begin
      tap_r <= hit ? data_r : '0;
    end
  end

endmodule

/* design/isq_or_tree.sv */
// Two-level OR tree that picks the one tapped cell word out of the chain.
module isq_or_tree (
  input  logic                           clk,
  input  logic [isq_pkg::DATA_WIDTH-1:0] taps [isq_pkg::CAPACITY],
  output logic [isq_pkg::DATA_WIDTH-1:0] word
);

  logic [isq_pkg::DATA_WIDTH-1:0] part_nxt [isq_pkg::NGROUPS];
  logic [isq_pkg::DATA_WIDTH-1:0] part_r   [isq_pkg::NGROUPS];

  always_comb begin
    for (int g = 0; g < isq_pkg::NGROUPS; g++) begin
      part_nxt[g] = '0;
      for (int j = 0; j < isq_pkg::GROUP; j++) begin
        if (g * isq_pkg::GROUP + j < isq_pkg::CAPACITY) begin
          part_nxt[g] = part_nxt[g] | taps[g * isq_pkg::GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    part_r <= part_nxt;
  end

  always_comb begin
    word = '0;
    for (int g = 0; g < isq_pkg::NGROUPS; g++) begin
      word = word | part_r[g];
    end
  end

endmodule

/* design/isq_checker.sv */
// Port-level checker for the sequence store, bound to the top level.
module isq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input isq_pkg::out_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == isq_pkg::ST_FULL)
      |-> (out_item.length == isq_pkg::LEN_W'(isq_pkg::CAPACITY)))
    else $error("full status with store not full");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != isq_pkg::ST_OK) |-> (out_item.data_out == '0))
    else $error("failed command returned data");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.length <= isq_pkg::LEN_W'(isq_pkg::CAPACITY)))
    else $error("length beyond capacity");

endmodule

bind indexed_sequence_store isq_checker u_isq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
